### hw/rtl/loglik_pkg.sv
// Package for the logistic log-likelihood unit: request codes, widths and the softplus table.
package loglik_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ELEM  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam int LL_NUM_COEFS = 64;
  localparam int OUT_DEPTH    = 8;

  localparam int REQ_W  = 2;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 32;
  localparam int PROD_W = 2 * VAL_W;
  localparam int Q_SH   = 16;
  localparam int ROW_W  = 48;
  localparam int LL_W   = 64;

  // softplus table: grid over [-16, 16) in Q16.16
  localparam int    SP_ENTRIES = 256;
  localparam int    SP_IDX_W   = $clog2(SP_ENTRIES);
  localparam int    SP_HALF_W  = 20;
  localparam int    SP_FRAC_W  = SP_HALF_W + 1 - SP_IDX_W;
  localparam longint SP_HALF   = 64'sd1 << SP_HALF_W;
  localparam longint SP_RANGE  = 64'sd1 << (SP_HALF_W + 1);
  localparam int    SP_PW      = SP_HALF_W + 1;
  localparam int    SP_DW      = SP_FRAC_W + 1;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef logic [SP_ENTRIES:0][SP_PW-1:0]   sp_pts_t;
  typedef logic [SP_ENTRIES-1:0][SP_DW-1:0] sp_diff_t;

  typedef struct packed {
    logic elem;
    logic clr;
    logic row_end;
    logic data_end;
    logic outcome;
    logic rsat;
  } stage_ctl_t;

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f) in Q2.30, f in Q16.16 within [0, 1]
  function automatic logic [63:0] expneg_frac(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] acc;
    term = ONE_Q30;
    acc  = ONE_Q30;
    for (int k = 1; k <= 24; k++) begin
      term = cdiv((term * f) >> 16, 64'(k));
      if (k[0]) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] expneg(input logic [63:0] a, input logic [63:0] e1);
    logic [63:0] r;
    logic [63:0] n;
    r = expneg_frac({48'd0, a[15:0]});
    n = a >> 16;
    for (int j = 0; j < 17; j++) begin
      if (64'(j) < n) r = (r * e1) >> 30;
    end
    return r;
  endfunction

  // ln(1+y) in Q2.30, y in [0, 1] Q2.30, atanh series
  function automatic logic [63:0] ln1p(input logic [63:0] y);
    logic [63:0] s;
    logic [63:0] s2;
    logic [63:0] pw;
    logic [63:0] acc;
    s   = cdiv(y << 30, (64'd2 << 30) + y);
    s2  = (s * s) >> 30;
    pw  = s;
    acc = '0;
    for (int k = 0; k < 20; k++) begin
      acc = acc + cdiv(pw, 64'(2 * k + 1));
      pw  = (pw * s2) >> 30;
    end
    return acc << 1;
  endfunction

  function automatic sp_pts_t sp_build();
    sp_pts_t            tab;
    logic [63:0]        e1;
    logic [63:0]        a;
    logic [63:0]        v;
    logic signed [63:0] x;
    logic signed [63:0] t;
    e1 = expneg_frac(64'd65536);
    for (int i = 0; i <= SP_ENTRIES; i++) begin
      x = -SP_HALF + (64'(i) * SP_RANGE) / SP_ENTRIES;
      a = (x < 0) ? -x : x;
      v = ln1p(expneg(a, e1));
      t = ((x > 0) ? x : 64'sd0) + $signed((v + 64'd8192) >> 14);
      tab[i] = t[SP_PW-1:0];
    end
    return tab;
  endfunction

  function automatic sp_diff_t sp_diffs(input sp_pts_t p);
    sp_diff_t              d;
    logic signed [SP_PW:0] dd;
    for (int i = 0; i < SP_ENTRIES; i++) begin
      dd = $signed({1'b0, p[i+1]}) - $signed({1'b0, p[i]});
      d[i] = (dd < 0) ? '0 : dd[SP_DW-1:0];
    end
    return d;
  endfunction

  localparam sp_pts_t  SP_PTS  = sp_build();
  localparam sp_diff_t SP_DIFF = sp_diffs(SP_PTS);

endpackage

### hw/rtl/logistic_log_likelihood_unit.sv
// Logistic log-likelihood unit: coefficient memory, row MAC, softplus and saturating total.
// Takes one word per clock while in_stall is low, for loads, design elements and clears alike.
// A design element reads its coefficient from the registered-read coefficient RAM, is multiplied,
// added to the row sum, and at row end passes through the softplus table and into the 64-bit
// total; the result word for a data-last element passes stages s1 to s5 into the result buffer.
// Results queue in an OUT_DEPTH-word buffer; in_stall rises only when OUT_DEPTH results are
// in flight or unread. There is no clearing pass after reset; coefficients must be loaded
// before use. The total persists across emissions until a clear request.
module logistic_log_likelihood_unit import loglik_pkg::*; #(
  parameter int NUM_COEFS = LL_NUM_COEFS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [COL_W-1:0]        in_col_index,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_outcome,
  input  logic                    in_row_last,
  input  logic                    in_data_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [LL_W-1:0]  out_log_likelihood,
  output logic                    out_saturated
);

  localparam int AW  = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
  localparam int PW  = $clog2(OUT_DEPTH);
  localparam int PCW = $clog2(OUT_DEPTH + 1);
  localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
  localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};
  localparam logic signed [LL_W-1:0]  TOT_MAX = {1'b0, {(LL_W-1){1'b1}}};
  localparam logic signed [LL_W-1:0]  TOT_MIN = {1'b1, {(LL_W-1){1'b0}}};
  localparam logic signed [ROW_W-1:0] SP_HI_LIM = ROW_W'(SP_HALF);
  localparam logic signed [ROW_W-1:0] SP_LO_LIM = -SP_HI_LIM;

  logic [VAL_W-1:0] coef_mem [NUM_COEFS];

  logic                     in_acc;
  logic                     col_ok;
  logic [AW-1:0]            col_addr;
  stage_ctl_t               s1_ctl_nxt;

  stage_ctl_t               s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r;
  logic signed [VAL_W-1:0]  s1_val_r;
  logic                     s1_colok_r;
  logic [VAL_W-1:0]         coef_rd_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [ROW_W-1:0]  s3_w_r, s4_w_r;
  logic                     s4_hi_r, s4_lo_r;
  logic [SP_PW-1:0]         s4_base_r;
  logic [SP_DW+SP_FRAC_W-1:0] s4_dprod_r;
  logic signed [ROW_W:0]    s5_c_r;

  logic signed [ROW_W-1:0]  row_sum_r, row_sum_nxt;
  logic signed [LL_W-1:0]   total_r, total_nxt;
  logic                     sat_r, sat_nxt;

  logic signed [VAL_W-1:0]  coef_s1;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ROW_W-1:0]  prod_q;
  logic signed [ROW_W:0]    row_add;
  logic                     row_ovf;
  logic signed [ROW_W-1:0]  row_new;
  stage_ctl_t               s3_ctl_nxt;

  logic                     sp_hi, sp_lo;
  logic [ROW_W-1:0]         sp_off;
  logic [SP_IDX_W-1:0]      sp_idx;
  logic [SP_FRAC_W-1:0]     sp_frac;
  logic [SP_PW:0]           sp_mid;
  logic signed [ROW_W-1:0]  sp_val;
  logic signed [ROW_W-1:0]  y_w;
  logic signed [ROW_W:0]    contrib;

  logic signed [LL_W:0]     tot_add;
  logic                     tot_ovf;
  logic signed [LL_W-1:0]   tot_new;

  logic signed [LL_W-1:0]   fifo_ll_r [OUT_DEPTH];
  logic                     fifo_sat_r [OUT_DEPTH];
  logic [PW:0]              wr_ptr_r, rd_ptr_r;
  logic [PW:0]              fifo_cnt;
  logic                     push, pop;
  logic [PCW-1:0]           pend_cnt_r, pend_cnt_nxt;
  logic                     pend_inc;

  // input side
  assign in_stall = (pend_cnt_r == PCW'(OUT_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign col_ok   = (32'(in_col_index) < 32'(NUM_COEFS));
  assign col_addr = AW'(in_col_index);
  assign pend_inc = in_acc && (in_req_type == REQ_ELEM) && in_data_last;

  always_comb begin
    s1_ctl_nxt          = '0;
    s1_ctl_nxt.elem     = in_acc && (in_req_type == REQ_ELEM);
    s1_ctl_nxt.clr      = in_acc && (in_req_type == REQ_CLEAR);
    s1_ctl_nxt.row_end  = in_row_last || in_data_last;
    s1_ctl_nxt.data_end = in_data_last;
    s1_ctl_nxt.outcome  = in_outcome;
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_req_type == REQ_LOAD) && col_ok) begin
      coef_mem[col_addr] <= in_value;
    end
    coef_rd_r <= coef_mem[col_addr];
  end

  // multiply
  assign coef_s1  = s1_colok_r ? $signed(coef_rd_r) : '0;
  assign prod_nxt = coef_s1 * s1_val_r;

  // row accumulate
  assign prod_q  = s2_prod_r[PROD_W-1:Q_SH];
  assign row_add = (ROW_W+1)'(row_sum_r) + (ROW_W+1)'(prod_q);
  assign row_ovf = row_add[ROW_W] ^ row_add[ROW_W-1];
  assign row_new = row_ovf ? (row_add[ROW_W] ? ROW_MIN : ROW_MAX) : row_add[ROW_W-1:0];

  always_comb begin
    row_sum_nxt     = row_sum_r;
    s3_ctl_nxt      = s2_ctl_r;
    s3_ctl_nxt.rsat = s2_ctl_r.elem && row_ovf;
    if (s2_ctl_r.clr) begin
      row_sum_nxt = '0;
    end else if (s2_ctl_r.elem) begin
      row_sum_nxt = s2_ctl_r.row_end ? '0 : row_new;
    end
  end

  // softplus lookup
  assign sp_hi   = (s3_w_r >= SP_HI_LIM);
  assign sp_lo   = (s3_w_r < SP_LO_LIM);
  assign sp_off  = s3_w_r + SP_HI_LIM;
  assign sp_idx  = sp_off[SP_HALF_W:SP_FRAC_W];
  assign sp_frac = sp_off[SP_FRAC_W-1:0];

  // row contribution
  assign sp_mid = (SP_PW+1)'(s4_base_r) + (SP_PW+1)'(s4_dprod_r >> SP_FRAC_W);

  always_comb begin
    priority if (s4_hi_r) begin
      sp_val = s4_w_r;
    end else if (s4_lo_r) begin
      sp_val = '0;
    end else begin
      sp_val = ROW_W'(sp_mid);
    end
    y_w     = s4_ctl_r.outcome ? s4_w_r : '0;
    contrib = s4_ctl_r.row_end ? ((ROW_W+1)'(y_w) - (ROW_W+1)'(sp_val)) : '0;
  end

  // total
  assign tot_add = (LL_W+1)'(total_r) + (LL_W+1)'(s5_c_r);
  assign tot_ovf = tot_add[LL_W] ^ tot_add[LL_W-1];
  assign tot_new = tot_ovf ? (tot_add[LL_W] ? TOT_MIN : TOT_MAX) : tot_add[LL_W-1:0];

  always_comb begin
    total_nxt = total_r;
    sat_nxt   = sat_r;
    if (s5_ctl_r.clr) begin
      total_nxt = '0;
      sat_nxt   = 1'b0;
    end else if (s5_ctl_r.elem) begin
      if (s5_ctl_r.row_end) total_nxt = tot_new;
      sat_nxt = sat_r || s5_ctl_r.rsat || (s5_ctl_r.row_end && tot_ovf);
    end
  end

  // result buffer
  assign push     = s5_ctl_r.elem && s5_ctl_r.data_end;
  assign fifo_cnt = wr_ptr_r - rd_ptr_r;
  assign out_valid = (wr_ptr_r != rd_ptr_r);
  assign pop      = out_valid && !out_stall;
  assign out_log_likelihood = fifo_ll_r[rd_ptr_r[PW-1:0]];
  assign out_saturated      = fifo_sat_r[rd_ptr_r[PW-1:0]];
  assign pend_cnt_nxt = pend_cnt_r + PCW'(pend_inc) - PCW'(pop);

  always_ff @(posedge clk) begin
    s1_val_r   <= in_value;
    s1_colok_r <= col_ok;
    s2_prod_r  <= prod_nxt;
    s3_w_r     <= row_new;
    s4_w_r     <= s3_w_r;
    s4_hi_r    <= sp_hi;
    s4_lo_r    <= sp_lo;
    s4_base_r  <= SP_PTS[sp_idx];
    s4_dprod_r <= (SP_DW+SP_FRAC_W)'(SP_DIFF[sp_idx]) * (SP_DW+SP_FRAC_W)'(sp_frac);
    s5_c_r     <= contrib;
    if (push) begin
      fifo_ll_r[wr_ptr_r[PW-1:0]]  <= total_nxt;
      fifo_sat_r[wr_ptr_r[PW-1:0]] <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r   <= '0;
      s2_ctl_r   <= '0;
      s3_ctl_r   <= '0;
      s4_ctl_r   <= '0;
      s5_ctl_r   <= '0;
      row_sum_r  <= '0;
      total_r    <= '0;
      sat_r      <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      pend_cnt_r <= '0;
    end else begin
      s1_ctl_r   <= s1_ctl_nxt;
      s2_ctl_r   <= s1_ctl_r;
      s3_ctl_r   <= s3_ctl_nxt;
      s4_ctl_r   <= s3_ctl_r;
      s5_ctl_r   <= s4_ctl_r;
      row_sum_r  <= row_sum_nxt;
      total_r    <= total_nxt;
      sat_r      <= sat_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= PCW'(OUT_DEPTH))
    else $error("pending result count above buffer depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt < (PW+1)'(OUT_DEPTH)))
    else $error("result buffer overflow");

  a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_cnt_r != '0))
    else $error("result word without pending count");

  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_ctl_r.elem && s2_ctl_r.row_end) |=> (row_sum_r == '0))
    else $error("row sum not cleared at row end");

  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s5_ctl_r.clr |=> ((total_r == '0) && !sat_r))
    else $error("clear request did not reset total");

endmodule
